/* sv/ip_mask_access_filter_defines.svh */
// assertion macros for the ip mask access filter
// used by the top level; expects clk and rst in scope
`ifndef IP_MASK_ACCESS_FILTER_DEFINES_SVH
`define IP_MASK_ACCESS_FILTER_DEFINES_SVH

// same-cycle implication
`define IMF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imf assertion failed");

// next-cycle implication
`define IMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imf assertion failed");

`endif

/* sv/imf_pkg.sv */
// types and constants for the ip mask access filter
// no dependencies
package imf_pkg;

  localparam int MAX_RULES = 64;
  localparam int IDX_W     = $clog2(MAX_RULES);
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic REG_DEFAULT_DENY = 1'b0;

  typedef struct packed {
    logic        cmd;
    logic [31:0] ip_address;
    logic [31:0] ip_mask;
    logic        rule_allows;
  } in_word_t;

  typedef struct packed {
    logic permitted;
    logic status;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] host;
    logic        hit;
  } token_t;

endpackage

/* sv/imf_cell.sv */
// one rule cell of the filter chain: holds one rule and passes the host token on
// depends on imf_pkg
module imf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [31:0]     wr_address,
  input  logic [31:0]     wr_mask,
  input  logic            wr_kind,
  input  logic            active,
  input  logic            default_deny,
  input  imf_pkg::token_t tok_in,
  output imf_pkg::token_t tok_out
);
  import imf_pkg::*;

  logic [31:0] rule_address;
  logic [31:0] rule_mask;
  logic        rule_kind;
  logic        match;

  // a rule counts only when its kind opposes the default policy
  assign match = active && (rule_kind == default_deny) &&
                 ((tok_in.host & rule_mask) == rule_address);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_address <= wr_address & wr_mask;
      rule_mask    <= wr_mask;
      rule_kind    <= wr_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.host <= tok_in.host;
    tok_out.hit  <= tok_in.hit | match;
  end

endmodule

/* sv/ip_mask_access_filter.sv */
// ip mask access filter top level: rule cell chain, result registers, apb register
// depends on imf_pkg, imf_cell and ip_mask_access_filter_defines.svh
// add: result goes through the holding stage to the output register; next word taken
// once the result leaves the holding stage. check: the host walks the chain one cell
// a cycle, then the holding stage and output register; no new word while one is in the chain
// synchronous reset clears rule count, policy bit and all valid flags; rule registers are not reset
`include "ip_mask_access_filter_defines.svh"

module ip_mask_access_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  imf_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output imf_pkg::out_word_t                out_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [imf_pkg::ADDR_W-1:0]        paddr,
  input  logic [imf_pkg::DATA_W-1:0]        pwdata,
  output logic [imf_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import imf_pkg::*;

  logic             default_deny;
  logic [CNT_W-1:0] rule_count;
  logic             busy;
  logic             pend_valid;
  out_word_t        pend_word;
  logic             in_accept;
  logic             add_ok;
  logic             table_full;
  token_t           inject;
  token_t           chain [MAX_RULES];
  logic             pend_load;
  out_word_t        pend_load_word;

  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_DEFAULT_DENY) ? {{(DATA_W-1){1'b0}}, default_deny}
                                                     : '0;
  assign in_ready   = !busy && !pend_valid;
  assign in_accept  = in_valid && in_ready;
  assign table_full = (rule_count == CNT_W'(MAX_RULES));
  assign add_ok     = in_accept && (in_word.cmd == CMD_ADD) && !table_full;

  assign inject.valid = in_accept && (in_word.cmd == CMD_CHECK);
  assign inject.host  = in_word.ip_address;
  assign inject.hit   = 1'b0;

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    token_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = inject;
    end else begin : g_link
      assign cell_in = chain[i-1];
    end
    imf_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .wr_en        (add_ok && (rule_count[IDX_W-1:0] == IDX_W'(i))),
      .wr_address   (in_word.ip_address),
      .wr_mask      (in_word.ip_mask),
      .wr_kind      (in_word.rule_allows),
      .active       (CNT_W'(i) < rule_count),
      .default_deny (default_deny),
      .tok_in       (cell_in),
      .tok_out      (chain[i])
    );
  end

  always_comb begin
    pend_load      = 1'b0;
    pend_load_word = '0;
    if (in_accept && (in_word.cmd == CMD_ADD)) begin
      pend_load             = 1'b1;
      pend_load_word.status = table_full;
    end else if (chain[MAX_RULES-1].valid) begin
      pend_load                = 1'b1;
      pend_load_word.permitted = ~(chain[MAX_RULES-1].hit ^ default_deny);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_deny <= 1'b0;
      rule_count   <= '0;
      busy         <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == REG_DEFAULT_DENY)) begin
        default_deny <= pwdata[0];
      end
      if (add_ok) begin
        rule_count <= rule_count + CNT_W'(1);
      end
      if (inject.valid) begin
        busy <= 1'b1;
      end else if (chain[MAX_RULES-1].valid) begin
        busy <= 1'b0;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && (!out_valid || out_ready)) begin
        pend_valid <= 1'b0;
      end
      if (pend_valid && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_word <= pend_load_word;
    end
    if (pend_valid && (!out_valid || out_ready)) begin
      out_word <= pend_word;
    end
  end

  `IMF_ASSERT_IMP(a_count_bound, 1'b1, rule_count <= CNT_W'(MAX_RULES))
  `IMF_ASSERT_IMP(a_tail_busy, chain[MAX_RULES-1].valid, busy && !pend_valid)
  `IMF_ASSERT_IMP(a_pend_idle, pend_valid, !busy)
  `IMF_ASSERT_NEXT(a_add_count, add_ok, rule_count == $past(rule_count) + CNT_W'(1))
  `IMF_ASSERT_NEXT(a_full_hold, in_accept && table_full, rule_count == CNT_W'(MAX_RULES))

endmodule
